@@ rtl/assert_macros.svh @@
// Assertion macros for the positional insert/delete list.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds on every clock edge.
`define PIL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define PIL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define PIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pil_pkg.sv @@
// Package for the positional insert/delete list: sizes, codes, cell commands
// and element conversion functions. Depends on nothing.
package pil_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CMP_BITS  = (CNT_BITS > 5) ? CNT_BITS : 5;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_INSERT     = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_POP_FRONT  = 3'd4,
    FN_REMOVE     = 3'd5,
    FN_READ       = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [IDX_BITS-1:0] at;
  } cell_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [CNT_BITS-1:0] held_next;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_idx;
  } ctrl_res_t;

  function automatic logic [ELEM_BITS-1:0] to_elem(input logic [31:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[ELEM_BITS-1:0];
  endfunction

  function automatic logic [31:0] from_elem(input logic [ELEM_BITS-1:0] e);
    logic [63:0] w;
    w = 64'($signed(e));
    return w[31:0];
  endfunction

endpackage

@@ rtl/pil_cell.sv @@
// One cell of the list chain: holds one element and loads it, or takes it
// from a neighbouring cell, as the broadcast command asks. Uses pil_pkg.
module pil_cell (
  input  logic                          clk,
  input  pil_pkg::cell_cmd_t            cmd,
  input  logic [pil_pkg::IDX_BITS-1:0]  idx,
  input  logic [pil_pkg::ELEM_BITS-1:0] elem_in,
  input  logic [pil_pkg::ELEM_BITS-1:0] from_lower,
  input  logic [pil_pkg::ELEM_BITS-1:0] from_upper,
  output logic [pil_pkg::ELEM_BITS-1:0] elem
);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pil_pkg::CELL_INSERT: begin
        if (idx == cmd.at) begin
          elem <= elem_in;
        end else if (idx > cmd.at) begin
          elem <= from_lower;
        end
      end
      pil_pkg::CELL_REMOVE: begin
        if (idx >= cmd.at) begin
          elem <= from_upper;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/pil_ctrl.sv @@
// Request decoder and entry counter for the list: checks full, empty and
// position, and issues the cell command. Uses pil_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pil_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2:0]               func,
  input  logic [4:0]               pos,
  output pil_pkg::cell_cmd_t       cmd,
  output pil_pkg::ctrl_res_t       res
);

  logic [pil_pkg::CNT_BITS-1:0] held;
  logic [pil_pkg::CMP_BITS-1:0] pos_c;
  logic [pil_pkg::CMP_BITS-1:0] held_c;
  logic                         full;
  logic                         empty;
  pil_pkg::cell_cmd_t           cmd_dec;

  assign pos_c  = pil_pkg::CMP_BITS'(pos);
  assign held_c = pil_pkg::CMP_BITS'(held);
  assign full   = (held == pil_pkg::CNT_BITS'(pil_pkg::CAPACITY));
  assign empty  = (held == '0);

  always_comb begin
    res.status    = pil_pkg::ST_DONE;
    res.held_next = held;
    res.rd_en     = 1'b0;
    res.rd_idx    = pil_pkg::IDX_BITS'(pos);
    cmd_dec.op    = pil_pkg::CELL_HOLD;
    cmd_dec.at    = '0;
    unique case (pil_pkg::func_t'(func))
      pil_pkg::FN_PUSH_BACK: begin
        if (full) begin
          res.status = pil_pkg::ST_FULL;
        end else begin
          cmd_dec.op    = pil_pkg::CELL_INSERT;
          cmd_dec.at    = pil_pkg::IDX_BITS'(held);
          res.held_next = held + pil_pkg::CNT_BITS'(1);
        end
      end
      pil_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          res.status = pil_pkg::ST_FULL;
        end else begin
          cmd_dec.op    = pil_pkg::CELL_INSERT;
          res.held_next = held + pil_pkg::CNT_BITS'(1);
        end
      end
      pil_pkg::FN_INSERT: begin
        if (full) begin
          res.status = pil_pkg::ST_FULL;
        end else if (pos_c > held_c) begin
          res.status = pil_pkg::ST_RANGE;
        end else begin
          cmd_dec.op    = pil_pkg::CELL_INSERT;
          cmd_dec.at    = pil_pkg::IDX_BITS'(pos);
          res.held_next = held + pil_pkg::CNT_BITS'(1);
        end
      end
      pil_pkg::FN_POP_BACK: begin
        if (empty) begin
          res.status = pil_pkg::ST_EMPTY;
        end else begin
          cmd_dec.op    = pil_pkg::CELL_REMOVE;
          cmd_dec.at    = pil_pkg::IDX_BITS'(held - pil_pkg::CNT_BITS'(1));
          res.held_next = held - pil_pkg::CNT_BITS'(1);
        end
      end
      pil_pkg::FN_POP_FRONT: begin
        if (empty) begin
          res.status = pil_pkg::ST_EMPTY;
        end else begin
          cmd_dec.op    = pil_pkg::CELL_REMOVE;
          res.held_next = held - pil_pkg::CNT_BITS'(1);
        end
      end
      pil_pkg::FN_REMOVE: begin
        if (empty) begin
          res.status = pil_pkg::ST_EMPTY;
        end else if (pos_c >= held_c) begin
          res.status = pil_pkg::ST_RANGE;
        end else begin
          cmd_dec.op    = pil_pkg::CELL_REMOVE;
          cmd_dec.at    = pil_pkg::IDX_BITS'(pos);
          res.held_next = held - pil_pkg::CNT_BITS'(1);
        end
      end
      pil_pkg::FN_READ: begin
        if (empty) begin
          res.status = pil_pkg::ST_EMPTY;
        end else if (pos_c >= held_c) begin
          res.status = pil_pkg::ST_RANGE;
        end else begin
          res.rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd = cmd_dec;
    if (!start) begin
      cmd.op = pil_pkg::CELL_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (start) begin
      held <= res.held_next;
    end
  end

  `PIL_ASSERT_ALWAYS(a_held_bound, held <= pil_pkg::CNT_BITS'(pil_pkg::CAPACITY), "count above capacity")
  `PIL_ASSERT_NEXT(a_insert_grows, cmd.op == pil_pkg::CELL_INSERT, held == $past(held) + pil_pkg::CNT_BITS'(1), "insert did not add an entry")
  `PIL_ASSERT_NEXT(a_fail_holds, start && res.status != pil_pkg::ST_DONE, $stable(held), "failed request changed the count")

endmodule

@@ rtl/positional_insert_delete_list.sv @@
// Top level of the positional insert/delete list: a chain of element cells,
// the request decoder and the result register. Uses pil_pkg, pil_ctrl,
// pil_cell and assert_macros.svh.
//
//   channel   ports                          handshake
//   request   func, value, pos               start (taken while busy is low)
//   result    status, count, read_value      done (one cycle, no back-pressure)
//
// One transaction per cycle: busy stays low, and the result of a transaction
// taken at one edge is shown with done in the next cycle.
// Every cell compares its index with the command position and moves in the
// same edge, so the whole chain shifts at once.
// Reset clears the entry count and done; the cell contents are left as they are.
`include "assert_macros.svh"

module positional_insert_delete_list (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic signed [31:0] value,
  input  logic [4:0]         pos,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         count,
  output logic signed [31:0] read_value
);

  pil_pkg::cell_cmd_t            cmd;
  pil_pkg::ctrl_res_t            res;
  logic [pil_pkg::ELEM_BITS-1:0] elem_in;
  logic [pil_pkg::ELEM_BITS-1:0] elems [pil_pkg::CAPACITY];
  logic [31:0]                   read_value_next;

  assign busy    = 1'b0;
  assign elem_in = pil_pkg::to_elem(value);

  pil_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .pos   (pos),
    .cmd   (cmd),
    .res   (res)
  );

  for (genvar i = 0; i < pil_pkg::CAPACITY; i++) begin : g_cell
    logic [pil_pkg::ELEM_BITS-1:0] lower;
    logic [pil_pkg::ELEM_BITS-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_inner_lo
      assign lower = elems[i-1];
    end
    if (i == pil_pkg::CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner_hi
      assign upper = elems[i+1];
    end
    pil_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (pil_pkg::IDX_BITS'(i)),
      .elem_in    (elem_in),
      .from_lower (lower),
      .from_upper (upper),
      .elem       (elems[i])
    );
  end

  always_comb begin
    read_value_next = '0;
    if (res.rd_en) begin
      read_value_next = pil_pkg::from_elem(elems[res.rd_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      status     <= res.status;
      count      <= 5'(res.held_next);
      read_value <= read_value_next;
    end
  end

  `PIL_ASSERT_NEXT(a_start_done, start, done, "transaction gave no result")
  `PIL_ASSERT_NEXT(a_idle_quiet, !start, !done, "result without a transaction")
  `PIL_ASSERT_IMPL(a_fail_zero, done && status != pil_pkg::ST_DONE, read_value == '0, "failed transaction returned data")

endmodule

@@ sim/positional_insert_delete_list_test.sv @@
// Self-checking testbench for positional_insert_delete_list: directed and random
// list transactions, with expected replies predicted from a shadow copy of the list.
// Depends on pil_pkg and the positional_insert_delete_list RTL.
module positional_insert_delete_list_test;
  import pil_pkg::*;

  localparam logic [2:0] FN_UNUSED   = 3'd7;
  localparam int         CYCLE_LIMIT = 60000;
  localparam int         IDLE_PCT    = 22;
  localparam int         RANDOM_REQS = 500;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    logic [4:0]  pos;
    bit          drain;
    bit          no_gap;
  } request_t;

  typedef struct {
    status_t     status;
    logic [4:0]  count;
    logic [31:0] rd;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         func = 3'd0;
  logic signed [31:0] value = 32'sd0;
  logic [4:0]         pos = 5'd0;
  logic               done;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] read_value;

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  request_t in_flight;

  logic [ELEM_BITS-1:0] shadow_list [CAPACITY];
  int unsigned          shadow_held = 0;
  int unsigned          peak_held = 0;
  int unsigned          gen_held = 0;

  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int checked = 0;
  int drains = 0;
  int status_hits [4] = '{0, 0, 0, 0};

  positional_insert_delete_list dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .pos       (pos),
    .done      (done),
    .status    (status),
    .count     (count),
    .read_value(read_value)
  );

  always #4 clk = ~clk;

  function automatic status_t insert_entry(int unsigned at, logic [31:0] v);
    if (shadow_held >= CAPACITY) return ST_FULL;
    if (at > shadow_held) return ST_RANGE;
    for (int unsigned i = shadow_held; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = ELEM_BITS'(v);
    shadow_held++;
    return ST_DONE;
  endfunction

  function automatic status_t remove_entry(int unsigned at);
    if (shadow_held == 0) return ST_EMPTY;
    if (at >= shadow_held) return ST_RANGE;
    for (int unsigned i = at; i + 1 < shadow_held; i++) shadow_list[i] = shadow_list[i+1];
    shadow_held--;
    return ST_DONE;
  endfunction

  function automatic reply_t apply_request(request_t r);
    reply_t                      rep;
    logic signed [ELEM_BITS-1:0] word;
    logic signed [63:0]          wide;
    rep.status = ST_DONE;
    rep.rd = 32'd0;
    case (r.op)
      FN_PUSH_BACK:  rep.status = insert_entry(shadow_held, r.value);
      FN_PUSH_FRONT: rep.status = insert_entry(0, r.value);
      FN_INSERT:     rep.status = insert_entry(r.pos, r.value);
      FN_POP_BACK:   rep.status = (shadow_held == 0) ? ST_EMPTY : remove_entry(shadow_held - 1);
      FN_POP_FRONT:  rep.status = remove_entry(0);
      FN_REMOVE:     rep.status = remove_entry(r.pos);
      FN_READ: begin
        if (shadow_held == 0) begin
          rep.status = ST_EMPTY;
        end else if (r.pos >= shadow_held) begin
          rep.status = ST_RANGE;
        end else begin
          word = shadow_list[r.pos];
          wide = word;
          rep.rd = wide[31:0];
        end
      end
      default: ;
    endcase
    rep.count = 5'(shadow_held);
    if (shadow_held > peak_held) peak_held = shadow_held;
    return rep;
  endfunction

  // Track occupancy at generation time so positions can be aimed at the live range.
  function automatic void queue_request(logic [2:0] op, logic [31:0] v, logic [4:0] p,
                                        bit drain = 1'b0, bit no_gap = 1'b0);
    request_t r;
    r = '{op, v, p, drain, no_gap};
    pending_requests.push_back(r);
    case (op)
      FN_PUSH_BACK, FN_PUSH_FRONT: if (gen_held < CAPACITY) gen_held++;
      FN_INSERT: if (gen_held < CAPACITY && p <= gen_held) gen_held++;
      FN_POP_BACK, FN_POP_FRONT: if (gen_held > 0) gen_held--;
      FN_REMOVE: if (gen_held > 0 && p < gen_held) gen_held--;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_pos(bit for_insert);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return 5'($urandom_range(0, 31));
    if (p < 20) return 5'($urandom_range(0, CAPACITY));
    if (for_insert) return 5'($urandom_range(0, gen_held));
    return (gen_held == 0) ? 5'd0 : 5'($urandom_range(0, gen_held - 1));
  endfunction

  always @(posedge clk) begin : drive_requests
    bit taken;
    bit launch;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_replies.push_back(apply_request(in_flight));
        accepted++;
      end
      if (!start || taken) begin
        launch = 1'b0;
        if (pending_requests.size() != 0) begin
          if (pending_requests[0].drain && expected_replies.size() != 0)
            launch = 1'b0;
          else if (!pending_requests[0].no_gap && $urandom_range(0, 99) < IDLE_PCT)
            launch = 1'b0;
          else
            launch = 1'b1;
        end
        if (launch) begin
          in_flight = pending_requests.pop_front();
          if (in_flight.drain) drains++;
          func  <= in_flight.op;
          value <= in_flight.value;
          pos   <= in_flight.pos;
        end
        start <= launch;
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none outstanding: status %0d count %0d read_value %0h",
                 $time, status, count, read_value);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        checked++;
        status_hits[want.status]++;
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
          errors++;
        end
        if (count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d", $time, want.count, count);
          errors++;
        end
        if (read_value !== want.rd) begin
          $display("%0t: read_value mismatch, expected %0h, got %0h",
                   $time, want.rd, read_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d replies outstanding",
               $time, cycles, expected_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          mode;
    int          seg_left;
    int          ins_weight;
    int          r;
    logic [2:0]  op;
    logic [31:0] v;
    logic [4:0]  p;

    queue_request(FN_POP_BACK, 32'h1234_5678, 5'd0);
    queue_request(FN_POP_FRONT, 32'h0, 5'd0);
    queue_request(FN_REMOVE, 32'h0, 5'd0);
    queue_request(FN_READ, 32'h0, 5'd0);
    queue_request(FN_UNUSED, 32'hffff_ffff, 5'd31);
    queue_request(FN_PUSH_BACK, 32'h7fff_ffff, 5'd31);
    queue_request(FN_PUSH_FRONT, 32'h8000_0000, 5'd0);
    queue_request(FN_INSERT, 32'hffff_ffff, 5'd1);
    queue_request(FN_INSERT, 32'h0000_0000, 5'd3);
    queue_request(FN_INSERT, 32'h5a5a_a5a5, 5'd6);
    queue_request(FN_INSERT, 32'ha5a5_5a5a, 5'd0);
    queue_request(FN_READ, 32'h0, 5'd0);
    queue_request(FN_READ, 32'h0, 5'd1);
    queue_request(FN_READ, 32'h0, 5'd4);
    queue_request(FN_READ, 32'h0, 5'd5);
    queue_request(FN_REMOVE, 32'h0, 5'd1);
    queue_request(FN_REMOVE, 32'h0, 5'd31);
    queue_request(FN_UNUSED, 32'h0, 5'd0);
    queue_request(FN_POP_BACK, 32'h0, 5'd0);
    queue_request(FN_POP_FRONT, 32'h0, 5'd0);
    queue_request(FN_READ, 32'h0, 5'd0);

    seg_left = 0;
    mode = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(15, 40);
      end
      seg_left--;
      ins_weight = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = FN_UNUSED;
        p = 5'($urandom_range(0, 31));
      end else if (r < 2 + ins_weight) begin
        case ($urandom_range(0, 2))
          0: op = FN_PUSH_BACK;
          1: op = FN_PUSH_FRONT;
          default: op = FN_INSERT;
        endcase
        p = (op == FN_INSERT) ? pick_pos(1'b1) : 5'($urandom_range(0, 31));
      end else if (r < 17 + ins_weight) begin
        op = FN_READ;
        p = pick_pos(1'b0);
      end else begin
        case ($urandom_range(0, 2))
          0: op = FN_POP_BACK;
          1: op = FN_POP_FRONT;
          default: op = FN_REMOVE;
        endcase
        p = (op == FN_REMOVE) ? pick_pos(1'b0) : 5'($urandom_range(0, 31));
      end
      v = pick_value();
      queue_request(op, v, p, (i % 125) == 60, i >= 250 && i < 330);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Hold until every transaction has been sent and answered.
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);

    $display("%0d transactions sent, %0d replies checked, %0d drain pauses, peak occupancy %0d",
             accepted, checked, drains, peak_held);
    $display("status seen: done %0d, full %0d, empty %0d, out of range %0d",
             status_hits[ST_DONE], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_RANGE]);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pil_pkg.sv
rtl/pil_cell.sv
rtl/pil_ctrl.sv
rtl/positional_insert_delete_list.sv
sim/positional_insert_delete_list_test.sv
